@@ rtl/srg_pkg.sv @@
package srg_pkg;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] row;
        logic [7:0] col;
        logic [7:0] pixel;
    } t_req;

    typedef struct packed {
        logic        mask_bit;
        logic [16:0] region_size;
        logic        grow_done;
    } t_rsp;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_GROW = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 9;

    localparam logic [CFG_AW-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [CFG_AW-1:0] REG_SEED_ROW  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_SEED_COL  = 3'd2;
    localparam logic [CFG_AW-1:0] REG_ROWS      = 3'd3;
    localparam logic [CFG_AW-1:0] REG_COLS      = 3'd4;

    localparam logic [7:0] THRESHOLD_RST = 8'd127;
    localparam logic [8:0] DIM_RST       = 9'd256;

    localparam logic [2:0] NB_LAST = 3'd7;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic start;
        logic clr;
        logic seed;
        logic pix_rd;
        logic nb_first;
        logic nb_rd;
        logic nb_next;
        logic mark;
        logic px_next;
        logic restart;
        logic out_grow;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic s1_v;
        logic out_free;
        logic clr_last;
        logic pix_skip;
        logic nb_hit;
        logic nb_last;
        logic px_last;
        logic changed;
    } t_sts;

endpackage

@@ rtl/seeded_region_growing.sv @@
// Seeded region growing, 8-connected, over a gray image held on chip. Requests carry a
// command: load pixel, grow region or read mask bit; each request gives exactly one
// response. Loads and reads are taken one per cycle while the output is free, and
// answer through the result stage and the output register. A grow first clears the
// whole mask memory, one entry a cycle (MAX_ROWS * 2**ceil(log2(MAX_COLS)) entries),
// marks the seed if it lies in the image, then repeats raster passes over the rows
// and columns in use until a pass marks nothing new. A pixel that is already marked
// or not below the threshold is skipped; otherwise its eight neighbours are read one
// at a time through the single mask read port until one is marked. The number of
// passes follows the shape of the region, so a grow takes from about one clear plus
// one pass to many passes. No request is taken while a grow runs. Configuration
// writes are always accepted and must only be made while the block is idle.
module seeded_region_growing #(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  srg_pkg::t_req              i_req,
    output logic                       o_valid,
    input  logic                       i_ready,
    output srg_pkg::t_rsp              o_rsp,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [srg_pkg::CFG_AW-1:0] i_cfg_index,
    input  logic [srg_pkg::CFG_DW-1:0] i_cfg_data
);

    srg_pkg::t_cmd cmd;
    srg_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    srg_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_req_cmd (i_req.cmd),
        .i_sts     (sts),
        .o_ready   (o_ready),
        .o_cmd     (cmd)
    );

    srg_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_ready     (i_ready),
        .o_valid     (o_valid),
        .o_rsp       (o_rsp)
    );

endmodule

@@ rtl/srg_ctrl.sv @@
module srg_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [1:0]    i_req_cmd,
    input  srg_pkg::t_sts i_sts,
    output logic          o_ready,
    output srg_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SEED,
        ST_P_READ,
        ST_P_CHECK,
        ST_NB_READ,
        ST_NB_CHECK,
        ST_MARK,
        ST_NEXT,
        ST_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = (r_state == ST_IDLE) && (!i_sts.s1_v || i_sts.out_free);
        case (r_state)
            ST_IDLE: begin
                o_cmd.accept = i_valid && o_ready;
                if (o_cmd.accept && i_req_cmd == srg_pkg::CMD_GROW) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_SEED;
                end
            end
            ST_SEED: begin
                o_cmd.seed = 1'b1;
                n_state    = ST_P_READ;
            end
            ST_P_READ: begin
                o_cmd.pix_rd = 1'b1;
                n_state      = ST_P_CHECK;
            end
            ST_P_CHECK: begin
                if (i_sts.pix_skip) begin
                    n_state = ST_NEXT;
                end else begin
                    o_cmd.nb_first = 1'b1;
                    n_state        = ST_NB_READ;
                end
            end
            ST_NB_READ: begin
                o_cmd.nb_rd = 1'b1;
                n_state     = ST_NB_CHECK;
            end
            ST_NB_CHECK: begin
                if (i_sts.nb_hit) begin
                    n_state = ST_MARK;
                end else if (i_sts.nb_last) begin
                    n_state = ST_NEXT;
                end else begin
                    o_cmd.nb_next = 1'b1;
                    n_state       = ST_NB_READ;
                end
            end
            ST_MARK: begin
                o_cmd.mark = 1'b1;
                n_state    = ST_NEXT;
            end
            ST_NEXT: begin
                if (!i_sts.px_last) begin
                    o_cmd.px_next = 1'b1;
                    n_state       = ST_P_READ;
                end else if (i_sts.changed) begin
                    o_cmd.restart = 1'b1;
                    n_state       = ST_P_READ;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_grow = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/srg_dp.sv @@
module srg_dp #(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [srg_pkg::CFG_AW-1:0]    i_cfg_index,
    input  logic [srg_pkg::CFG_DW-1:0]    i_cfg_data,
    input  srg_pkg::t_req                 i_req,
    input  srg_pkg::t_cmd                 i_cmd,
    output srg_pkg::t_sts                 o_sts,
    input  logic                          i_ready,
    output logic                          o_valid,
    output srg_pkg::t_rsp                 o_rsp
);

    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int AW    = RW + CW;
    localparam int NRW   = RW + 1;
    localparam int NCW   = CW + 1;
    localparam int DEPTH = MAX_ROWS * (2 ** CW);
    localparam int CNTW  = $clog2(MAX_ROWS * MAX_COLS + 1);

    logic [7:0]     r_thr;
    logic [7:0]     r_seed_row;
    logic [7:0]     r_seed_col;
    logic [8:0]     r_rows;
    logic [8:0]     r_cols;

    logic           r_mask_mem [0:DEPTH-1];
    logic [7:0]     r_img_mem  [0:DEPTH-1];
    logic           r_mask_rd;
    logic [7:0]     r_img_rd;

    logic [NRW-1:0] r_nr;
    logic [NCW-1:0] r_nc;
    logic [RW-1:0]  r_r;
    logic [CW-1:0]  r_c;
    logic [2:0]     r_k;
    logic           r_nb_inb;
    logic [AW-1:0]  r_clr;
    logic [CNTW-1:0] r_count;
    logic           r_changed;
    logic           r_grown;

    logic           r_s1_v;
    logic           r_s1_rd;
    logic           r_o_valid;
    srg_pkg::t_rsp  r_rsp;

    logic           req_ok;
    logic [AW-1:0]  req_addr;
    logic [NRW-1:0] n_nr;
    logic [NCW-1:0] n_nc;
    logic           seed_ok;
    logic [AW-1:0]  seed_addr;
    logic [AW-1:0]  pix_addr;
    logic           up, dn, lf, rt;
    logic           row_nxt_ok, col_nxt_ok;
    logic [RW-1:0]  rr;
    logic [CW-1:0]  cc;
    logic           inb;
    logic [AW-1:0]  nb_addr;
    logic           mask_we, mask_wd, mask_re;
    logic [AW-1:0]  mask_wa, mask_ra;
    logic           img_we;
    logic           out_free;
    logic           col_last, row_last;

    // request decode
    assign req_ok   = (32'(i_req.row) < MAX_ROWS) && (32'(i_req.col) < MAX_COLS);
    assign req_addr = {RW'(i_req.row), CW'(i_req.col)};

    // image size saturation
    always_comb begin
        if (r_rows == '0) begin
            n_nr = NRW'(1);
        end else if (32'(r_rows) > MAX_ROWS) begin
            n_nr = NRW'(MAX_ROWS);
        end else begin
            n_nr = NRW'(r_rows);
        end
        if (r_cols == '0) begin
            n_nc = NCW'(1);
        end else if (32'(r_cols) > MAX_COLS) begin
            n_nc = NCW'(MAX_COLS);
        end else begin
            n_nc = NCW'(r_cols);
        end
    end

    assign seed_ok   = (32'(r_seed_row) < 32'(r_nr)) && (32'(r_seed_col) < 32'(r_nc));
    assign seed_addr = {RW'(r_seed_row), CW'(r_seed_col)};
    assign pix_addr  = {r_r, r_c};

    // neighbour k of the 3x3 window, centre left out
    always_comb begin
        up = 1'b0;
        dn = 1'b0;
        lf = 1'b0;
        rt = 1'b0;
        case (r_k)
            3'd0: begin up = 1'b1; lf = 1'b1; end
            3'd1: begin up = 1'b1; end
            3'd2: begin up = 1'b1; rt = 1'b1; end
            3'd3: begin lf = 1'b1; end
            3'd4: begin rt = 1'b1; end
            3'd5: begin dn = 1'b1; lf = 1'b1; end
            3'd6: begin dn = 1'b1; end
            default: begin dn = 1'b1; rt = 1'b1; end
        endcase
    end

    assign row_nxt_ok = (NRW'(r_r) + NRW'(1)) < r_nr;
    assign col_nxt_ok = (NCW'(r_c) + NCW'(1)) < r_nc;
    assign row_last   = !row_nxt_ok;
    assign col_last   = !col_nxt_ok;
    assign rr = up ? (r_r - RW'(1)) : (dn ? (r_r + RW'(1)) : r_r);
    assign cc = lf ? (r_c - CW'(1)) : (rt ? (r_c + CW'(1)) : r_c);
    assign inb = (!up || r_r != '0) && (!dn || row_nxt_ok)
              && (!lf || r_c != '0) && (!rt || col_nxt_ok);
    assign nb_addr = inb ? {rr, cc} : pix_addr;

    // memory port selection
    assign mask_we = i_cmd.clr || (i_cmd.seed && seed_ok) || i_cmd.mark;
    assign mask_wd = !i_cmd.clr;
    assign mask_wa = i_cmd.clr ? r_clr : (i_cmd.seed ? seed_addr : pix_addr);
    assign mask_re = (i_cmd.accept && i_req.cmd == srg_pkg::CMD_READ && req_ok)
                  || i_cmd.pix_rd || i_cmd.nb_rd;
    assign mask_ra = i_cmd.accept ? req_addr : (i_cmd.nb_rd ? nb_addr : pix_addr);
    assign img_we  = i_cmd.accept && i_req.cmd == srg_pkg::CMD_LOAD && req_ok;

    always_ff @(posedge i_clk) begin
        if (mask_we) begin
            r_mask_mem[mask_wa] <= mask_wd;
        end
        if (mask_re) begin
            r_mask_rd <= r_mask_mem[mask_ra];
        end
        if (img_we) begin
            r_img_mem[req_addr] <= i_req.pixel;
        end
        if (i_cmd.pix_rd) begin
            r_img_rd <= r_img_mem[pix_addr];
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr      <= srg_pkg::THRESHOLD_RST;
            r_seed_row <= '0;
            r_seed_col <= '0;
            r_rows     <= srg_pkg::DIM_RST;
            r_cols     <= srg_pkg::DIM_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                srg_pkg::REG_THRESHOLD: r_thr      <= i_cfg_data[7:0];
                srg_pkg::REG_SEED_ROW:  r_seed_row <= i_cfg_data[7:0];
                srg_pkg::REG_SEED_COL:  r_seed_col <= i_cfg_data[7:0];
                srg_pkg::REG_ROWS:      r_rows     <= i_cfg_data;
                srg_pkg::REG_COLS:      r_cols     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // scan registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_nr  <= n_nr;
            r_nc  <= n_nc;
            r_clr <= '0;
        end
        if (i_cmd.clr) begin
            r_clr <= r_clr + AW'(1);
        end
        if (i_cmd.seed || i_cmd.restart) begin
            r_r <= '0;
            r_c <= '0;
        end
        if (i_cmd.px_next) begin
            if (col_last) begin
                r_c <= '0;
                r_r <= r_r + RW'(1);
            end else begin
                r_c <= r_c + CW'(1);
            end
        end
        if (i_cmd.nb_first) begin
            r_k <= '0;
        end
        if (i_cmd.nb_next) begin
            r_k <= r_k + 3'd1;
        end
        if (i_cmd.nb_rd) begin
            r_nb_inb <= inb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_changed <= 1'b0;
            r_grown   <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_grown <= 1'b1;
            end
            if (i_cmd.seed) begin
                r_count   <= seed_ok ? CNTW'(1) : '0;
                r_changed <= 1'b0;
            end
            if (i_cmd.restart) begin
                r_changed <= 1'b0;
            end
            if (i_cmd.mark) begin
                r_count   <= r_count + CNTW'(1);
                r_changed <= 1'b1;
            end
        end
    end

    // result stage and output register
    assign out_free = !r_o_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.accept && i_req.cmd != srg_pkg::CMD_GROW) begin
                r_s1_v <= 1'b1;
            end else if (out_free) begin
                r_s1_v <= 1'b0;
            end
            if (r_s1_v && out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_cmd.out_grow) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_s1_rd <= (i_req.cmd == srg_pkg::CMD_READ) && req_ok && r_grown;
        end
        if (r_s1_v && out_free) begin
            r_rsp.mask_bit    <= r_s1_rd && r_mask_rd;
            r_rsp.region_size <= '0;
            r_rsp.grow_done   <= 1'b0;
        end else if (i_cmd.out_grow) begin
            r_rsp.mask_bit    <= 1'b0;
            r_rsp.region_size <= 17'(r_count);
            r_rsp.grow_done   <= 1'b1;
        end
    end

    assign o_valid = r_o_valid;
    assign o_rsp   = r_rsp;

    assign o_sts.s1_v     = r_s1_v;
    assign o_sts.out_free = out_free;
    assign o_sts.clr_last = (r_clr == AW'(DEPTH - 1));
    assign o_sts.pix_skip = r_mask_rd || (r_img_rd >= r_thr);
    assign o_sts.nb_hit   = r_nb_inb && r_mask_rd;
    assign o_sts.nb_last  = (r_k == srg_pkg::NB_LAST);
    assign o_sts.px_last  = row_last && col_last;
    assign o_sts.changed  = r_changed;

endmodule
